// File: design/pngidat_pkg.sv
// ----------------------------------------------------------------------------
// pngidat_pkg
// Shared types, constants and the CRC-32 byte update for the IDAT chunk framer.
// ----------------------------------------------------------------------------
`default_nettype none

package pngidat_pkg;

    localparam int MAX_CHUNK_DEF = 256;

    localparam int FILL_W   = 9;
    localparam int CFG_W    = 9;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;
    localparam int WORD_W   = 64;
    localparam int COUNT_W  = 4;

    localparam logic [CFG_W-1:0] CHUNK_SIZE_RST = 9'd256;

    localparam logic CFG_IDX_CHUNK_SIZE = 1'b0;

    localparam logic [31:0] CRC_SEED = 32'hCA50F9E1;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_XOR  = 32'hFFFFFFFF;
    localparam logic [31:0] IDAT_TAG = 32'h49444154;

    localparam logic [COUNT_W-1:0] HDR_BYTES = 4'd8;
    localparam logic [COUNT_W-1:0] CRC_BYTES = 4'd4;
    localparam logic [COUNT_W-1:0] WORD_BYTES = 4'd8;

    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_CRC  = 2'd2
    } kind_t;

    function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/pngidat_ram.sv
// ----------------------------------------------------------------------------
// pngidat_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pngidat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                               aclk,
    input  wire logic                               we,
    input  wire logic [$clog2(DEPTH)-1:0]           waddr,
    input  wire logic [WIDTH-1:0]                   wdata,
    input  wire logic                               re,
    input  wire logic [$clog2(DEPTH)-1:0]           raddr,
    output      logic [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/png_idat_chunk_framer_top.sv
// ----------------------------------------------------------------------------
// png_idat_chunk_framer_top
// Packs a compressed byte stream into PNG IDAT chunks with a running CRC-32.
// ----------------------------------------------------------------------------
// A data byte is taken every cycle while the framer is idle. A byte that finds
// room in the chunk buffer is written to the chunk store and folded into the
// CRC in that cycle; a byte that finds it full is held and starts the next
// chunk. When a chunk is sent, the input is held until the CRC word is
// registered, also while the result side stalls, because the store is read
// back through its single read port at one byte per cycle and each packed
// word is gathered and then presented. A finish word with an empty buffer is
// taken and gives no result. The store needs no clearing after reset: only
// entries written since the last chunk are read back.
// ----------------------------------------------------------------------------
`default_nettype none

module png_idat_chunk_framer_top
    import pngidat_pkg::*;
#(
    parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire logic                  s_mode,
    input  wire logic [7:0]            s_data_byte,

    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      logic [WORD_W-1:0]     m_out_word,
    output      logic [COUNT_W-1:0]    m_byte_count,
    output      logic [1:0]            m_word_kind,
    output      logic                  m_last,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output      logic [APB_DW-1:0]     prdata,
    output      logic                  pready
);

    localparam int ADDR_W = $clog2(MAX_CHUNK);
    localparam int LIM    = (MAX_CHUNK < 256) ? MAX_CHUNK : 256;
    localparam logic [FILL_W-1:0] LIM_F = FILL_W'(LIM);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_READ,
        S_WOUT,
        S_CRC
    } state_t;

    state_t               state_reg,      state_next;
    logic [CFG_W-1:0]     chunk_size_reg, chunk_size_next;
    logic [FILL_W-1:0]    fill_reg,       fill_next;
    logic [31:0]          crc_reg,        crc_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [7:0]           pend_byte_reg,  pend_byte_next;
    logic [FILL_W-1:0]    ipos_reg,       ipos_next;
    logic [COUNT_W-1:0]   icnt_reg,       icnt_next;
    logic [COUNT_W-1:0]   wlen_reg,       wlen_next;
    logic                 rd_pend_reg,    rd_pend_next;
    logic [2:0]           rd_slot_reg,    rd_slot_next;
    logic [WORD_W-1:0]    acc_reg,        acc_next;
    logic                 m_valid_reg,    m_valid_next;
    logic [WORD_W-1:0]    m_word_reg,     m_word_next;
    logic [COUNT_W-1:0]   m_count_reg,    m_count_next;
    kind_t                m_kind_reg,     m_kind_next;
    logic                 m_last_reg,     m_last_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [7:0]           ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [7:0]           ram_rdata;

    logic [FILL_W-1:0]    eff_size;
    logic                 buf_full;
    logic                 s_fire;
    logic                 out_free;
    logic                 cfg_wr;
    logic [5:0]           slot_base;

    function automatic logic [COUNT_W-1:0] word_len(logic [FILL_W-1:0] n,
                                                    logic [FILL_W-1:0] pos);
        logic [FILL_W-1:0] rem;
        rem = n - pos;
        return (rem >= FILL_W'(WORD_BYTES)) ? WORD_BYTES : rem[COUNT_W-1:0];
    endfunction

    pngidat_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHUNK)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == CFG_IDX_CHUNK_SIZE)
                    ? {{(APB_DW-CFG_W){1'b0}}, chunk_size_reg} : '0;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign eff_size = (chunk_size_reg == '0) ? FILL_W'(1)
                    : ((chunk_size_reg > LIM_F) ? LIM_F : chunk_size_reg);
    assign buf_full = (fill_reg >= eff_size);

    assign slot_base = {3'd7 - rd_slot_reg, 3'd0};

    assign m_valid      = m_valid_reg;
    assign m_out_word   = m_word_reg;
    assign m_byte_count = m_count_reg;
    assign m_word_kind  = m_kind_reg;
    assign m_last       = m_last_reg;

    always_comb begin
        state_next      = state_reg;
        chunk_size_next = chunk_size_reg;
        fill_next       = fill_reg;
        crc_next        = crc_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        ipos_next       = ipos_reg;
        icnt_next       = icnt_reg;
        wlen_next       = wlen_reg;
        rd_pend_next    = rd_pend_reg;
        rd_slot_next    = rd_slot_reg;
        acc_next        = acc_reg;
        m_valid_next    = m_valid_reg;
        m_word_next     = m_word_reg;
        m_count_next    = m_count_reg;
        m_kind_next     = m_kind_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = ADDR_W'(fill_reg);
        ram_wdata       = s_data_byte;
        ram_re          = 1'b0;
        ram_raddr       = ADDR_W'(ipos_reg);

        if (cfg_wr && (paddr[2] == CFG_IDX_CHUNK_SIZE)) begin
            chunk_size_next = pwdata[CFG_W-1:0];
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_mode) begin
                        if (fill_reg != '0) begin
                            pend_valid_next = 1'b0;
                            state_next      = S_HDR;
                        end
                    end else if (buf_full) begin
                        pend_valid_next = 1'b1;
                        pend_byte_next  = s_data_byte;
                        state_next      = S_HDR;
                    end else begin
                        ram_we    = 1'b1;
                        crc_next  = crc_byte(crc_reg, s_data_byte);
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            S_HDR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = {{(32-FILL_W){1'b0}}, fill_reg, IDAT_TAG};
                    m_count_next = HDR_BYTES;
                    m_kind_next  = KIND_HDR;
                    m_last_next  = 1'b0;
                    ipos_next    = '0;
                    icnt_next    = '0;
                    wlen_next    = word_len(fill_reg, '0);
                    acc_next     = '0;
                    rd_pend_next = 1'b0;
                    state_next   = S_READ;
                end
            end
            S_READ: begin
                rd_pend_next = 1'b0;
                if (rd_pend_reg) begin
                    acc_next[slot_base +: 8] = ram_rdata;
                end
                if (icnt_reg != wlen_reg) begin
                    ram_re       = 1'b1;
                    ipos_next    = ipos_reg + 1'b1;
                    icnt_next    = icnt_reg + 1'b1;
                    rd_pend_next = 1'b1;
                    rd_slot_next = icnt_reg[2:0];
                end else if (rd_pend_reg) begin
                    state_next = S_WOUT;
                end
            end
            S_WOUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = acc_reg;
                    m_count_next = wlen_reg;
                    m_kind_next  = KIND_DATA;
                    m_last_next  = 1'b0;
                    if (ipos_reg == fill_reg) begin
                        state_next = S_CRC;
                    end else begin
                        wlen_next  = word_len(fill_reg, ipos_reg);
                        icnt_next  = '0;
                        acc_next   = '0;
                        state_next = S_READ;
                    end
                end
            end
            S_CRC: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_word_next     = {crc_reg ^ CRC_XOR, 32'd0};
                    m_count_next    = CRC_BYTES;
                    m_kind_next     = KIND_CRC;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                    if (pend_valid_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = pend_byte_reg;
                        crc_next  = crc_byte(CRC_SEED, pend_byte_reg);
                        fill_next = FILL_W'(1);
                    end else begin
                        crc_next  = CRC_SEED;
                        fill_next = '0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            chunk_size_reg <= CHUNK_SIZE_RST;
            fill_reg       <= '0;
            crc_reg        <= CRC_SEED;
            pend_valid_reg <= 1'b0;
            pend_byte_reg  <= '0;
            ipos_reg       <= '0;
            icnt_reg       <= '0;
            wlen_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            rd_slot_reg    <= '0;
            acc_reg        <= '0;
            m_valid_reg    <= 1'b0;
            m_word_reg     <= '0;
            m_count_reg    <= '0;
            m_kind_reg     <= KIND_HDR;
            m_last_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            chunk_size_reg <= chunk_size_next;
            fill_reg       <= fill_next;
            crc_reg        <= crc_next;
            pend_valid_reg <= pend_valid_next;
            pend_byte_reg  <= pend_byte_next;
            ipos_reg       <= ipos_next;
            icnt_reg       <= icnt_next;
            wlen_reg       <= wlen_next;
            rd_pend_reg    <= rd_pend_next;
            rd_slot_reg    <= rd_slot_next;
            acc_reg        <= acc_next;
            m_valid_reg    <= m_valid_next;
            m_word_reg     <= m_word_next;
            m_count_reg    <= m_count_next;
            m_kind_reg     <= m_kind_next;
            m_last_reg     <= m_last_next;
        end
    end

endmodule

`default_nettype wire

// File: design/pngidat_checker.sv
// ----------------------------------------------------------------------------
// pngidat_checker
// Port-level checks on the result words of the IDAT chunk framer.
// ----------------------------------------------------------------------------
`default_nettype none

module pngidat_checker
    import pngidat_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [WORD_W-1:0]     m_out_word,
    input  wire logic [COUNT_W-1:0]    m_byte_count,
    input  wire logic [1:0]            m_word_kind,
    input  wire logic                  m_last
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_word)
            && $stable(m_byte_count) && $stable(m_word_kind) && $stable(m_last))
        else $error("result word changed while stalled");

    // The last flag marks the CRC word and nothing else.
    a_last_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_word_kind == KIND_CRC)))
        else $error("last flag does not match the CRC word");

    // Header words carry the tag and a nonzero length in a full word.
    a_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_word_kind == KIND_HDR) |->
            (m_out_word[31:0] == IDAT_TAG) && (m_out_word[63:32] != 32'd0)
            && (m_byte_count == HDR_BYTES))
        else $error("malformed header word");

    // Data words hold one to eight bytes, CRC words four bytes.
    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_word_kind == KIND_DATA) && (m_byte_count != 4'd0)
                        && (m_byte_count <= WORD_BYTES))
                 || ((m_word_kind == KIND_CRC) && (m_byte_count == CRC_BYTES)
                        && (m_out_word[31:0] == 32'd0))
                 || (m_word_kind == KIND_HDR))
        else $error("bad byte count or word kind");

endmodule

bind png_idat_chunk_framer_top pngidat_checker u_pngidat_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_word   (m_out_word),
    .m_byte_count (m_byte_count),
    .m_word_kind  (m_word_kind),
    .m_last       (m_last)
);

`default_nettype wire
